// ===== design/stsm_pkg.sv =====
// Package for the sparse triplet subtract merge unit: sizes, codes and the list entry type.
package stsm_pkg;

  localparam int CAPACITY = 32;
  localparam int MAX_DIM  = 256;
  localparam int MAX_OUT  = 64;

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int NOUT_W = $clog2(MAX_OUT + 1);
  localparam int IDX_W  = 6;

  localparam logic [1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  localparam logic [1:0] ST_ENTRY    = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] value;
  } entry_t;

endpackage

// ===== design/sparse_triplet_subtract_merge_unit.sv =====
// Top level of the sparse triplet subtract merge unit: list memories, merge sequencer, output.
// A load writes its entry to its list; a full-list load gives its status item the next cycle.
// Compute: after the accept, each merge step passes the list RAM read register (S_FETCH), then
//   the shared compare/subtract unit (S_STEP); steps = len A + len B - matches. A last S_FETCH
//   sees both lists done, then S_FINISH gives the last item. One request is in work at a time.
// Results leave through one output register; the merge stalls while it is full and not taken.
// Reset (rst_n low, synchronous): counts zero, output empty, sequencer idle; lists not cleared.
module sparse_triplet_subtract_merge_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_row,
  input  logic [7:0]         in_col,
  input  logic signed [31:0] in_value,
  input  logic [8:0]         in_a_rows,
  input  logic [8:0]         in_a_cols,
  input  logic [8:0]         in_b_rows,
  input  logic [8:0]         in_b_cols,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [7:0]         out_row,
  output logic [7:0]         out_col,
  output logic signed [32:0] out_value,
  output logic [5:0]         out_entry_index,
  output logic [8:0]         out_result_rows,
  output logic [8:0]         out_result_cols,
  output logic               out_last
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FETCH  = 2'd1;
  localparam logic [1:0] S_STEP   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  // list storage (single write port, registered read)
  stsm_pkg::entry_t mem_a [stsm_pkg::CAPACITY];
  stsm_pkg::entry_t mem_b [stsm_pkg::CAPACITY];
  stsm_pkg::entry_t rd_a_r, rd_b_r;

  logic [1:0]                    state_r, state_nxt;
  logic [stsm_pkg::CNT_W-1:0]    cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [stsm_pkg::CNT_W-1:0]    ia_r, ia_nxt, ib_r, ib_nxt;
  logic [stsm_pkg::NOUT_W-1:0]   n_r, n_nxt;
  logic [8:0]                    ar_r, ar_nxt, ac_r, ac_nxt;

  // held-back result: last is known only once the next one exists or the merge ends
  logic                          pend_v_r, pend_v_nxt;
  logic [7:0]                    pend_row_r, pend_row_nxt, pend_col_r, pend_col_nxt;
  logic [32:0]                   pend_val_r, pend_val_nxt;
  logic [stsm_pkg::IDX_W-1:0]    pend_idx_r, pend_idx_nxt;

  logic                          ov_r, ov_nxt;
  logic [1:0]                    os_r, os_nxt;
  logic [7:0]                    orow_r, orow_nxt, ocol_r, ocol_nxt;
  logic [32:0]                   oval_r, oval_nxt;
  logic [stsm_pkg::IDX_W-1:0]    oidx_r, oidx_nxt;
  logic [8:0]                    orr_r, orr_nxt, orc_r, orc_nxt;
  logic                          olast_r, olast_nxt;

  logic        out_free, accept, wr_a, wr_b, dims_ok;
  logic        a_has, b_has, take_a, take_b, emit_c, room;
  logic [15:0] ka, kb;
  logic [32:0] sub_x, sub_y, diff;
  stsm_pkg::entry_t in_entry;

  assign out_free = !ov_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign in_entry = '{row: in_row, col: in_col, value: in_value};
  assign wr_a = accept && (in_mode == stsm_pkg::MODE_LOAD_A) &&
                (32'(cnt_a_r) < 32'(stsm_pkg::CAPACITY));
  assign wr_b = accept && (in_mode == stsm_pkg::MODE_LOAD_B) &&
                (32'(cnt_b_r) < 32'(stsm_pkg::CAPACITY));

  assign dims_ok = (in_a_rows == in_b_rows) && (in_a_cols == in_b_cols) &&
                   (in_a_rows != 9'd0) && (in_a_cols != 9'd0) &&
                   (32'(in_a_rows) <= 32'(stsm_pkg::MAX_DIM)) &&
                   (32'(in_a_cols) <= 32'(stsm_pkg::MAX_DIM));

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[cnt_a_r[stsm_pkg::ADDR_W-1:0]] <= in_entry;
    end
    if (wr_b) begin
      mem_b[cnt_b_r[stsm_pkg::ADDR_W-1:0]] <= in_entry;
    end
    rd_a_r <= mem_a[ia_r[stsm_pkg::ADDR_W-1:0]];
    rd_b_r <= mem_b[ib_r[stsm_pkg::ADDR_W-1:0]];
  end

  // shared compare / subtract unit; an absent operand enters as zero
  assign a_has  = ia_r < cnt_a_r;
  assign b_has  = ib_r < cnt_b_r;
  assign ka     = {rd_a_r.row, rd_a_r.col};
  assign kb     = {rd_b_r.row, rd_b_r.col};
  assign take_a = a_has && (!b_has || (ka <= kb));
  assign take_b = b_has && (!a_has || (kb <= ka));
  assign sub_x  = take_a ? {rd_a_r.value[31], rd_a_r.value} : 33'd0;
  assign sub_y  = take_b ? {rd_b_r.value[31], rd_b_r.value} : 33'd0;
  assign diff   = sub_x - sub_y;
  // matched entries that cancel give no result
  assign emit_c = !(take_a && take_b) || (diff != 33'd0);
  assign room   = 32'(n_r) < 32'(stsm_pkg::MAX_OUT);

  always_comb begin
    state_nxt    = state_r;
    cnt_a_nxt    = cnt_a_r;
    cnt_b_nxt    = cnt_b_r;
    ia_nxt       = ia_r;
    ib_nxt       = ib_r;
    n_nxt        = n_r;
    ar_nxt       = ar_r;
    ac_nxt       = ac_r;
    pend_v_nxt   = pend_v_r;
    pend_row_nxt = pend_row_r;
    pend_col_nxt = pend_col_r;
    pend_val_nxt = pend_val_r;
    pend_idx_nxt = pend_idx_r;
    ov_nxt       = ov_r && !out_ready;
    os_nxt       = os_r;
    orow_nxt     = orow_r;
    ocol_nxt     = ocol_r;
    oval_nxt     = oval_r;
    oidx_nxt     = oidx_r;
    orr_nxt      = orr_r;
    orc_nxt      = orc_r;
    olast_nxt    = olast_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            stsm_pkg::MODE_LOAD_A, stsm_pkg::MODE_LOAD_B: begin
              if (wr_a) begin
                cnt_a_nxt = cnt_a_r + 1'b1;
              end else if (wr_b) begin
                cnt_b_nxt = cnt_b_r + 1'b1;
              end else begin
                // list full: entry dropped, flag it
                ov_nxt    = 1'b1;
                os_nxt    = stsm_pkg::ST_FULL;
                orow_nxt  = '0;
                ocol_nxt  = '0;
                oval_nxt  = '0;
                oidx_nxt  = '0;
                orr_nxt   = '0;
                orc_nxt   = '0;
                olast_nxt = 1'b1;
              end
            end
            stsm_pkg::MODE_COMPUTE: begin
              if (!dims_ok) begin
                ov_nxt    = 1'b1;
                os_nxt    = stsm_pkg::ST_MISMATCH;
                orow_nxt  = '0;
                ocol_nxt  = '0;
                oval_nxt  = '0;
                oidx_nxt  = '0;
                orr_nxt   = '0;
                orc_nxt   = '0;
                olast_nxt = 1'b1;
                cnt_a_nxt = '0;
                cnt_b_nxt = '0;
              end else begin
                ar_nxt     = in_a_rows;
                ac_nxt     = in_a_cols;
                ia_nxt     = '0;
                ib_nxt     = '0;
                n_nxt      = '0;
                pend_v_nxt = 1'b0;
                state_nxt  = S_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FETCH: begin
        // list RAM read of ia/ib lands in rd_*_r this cycle
        if (!a_has && !b_has) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (out_free) begin
          if (take_a) begin
            ia_nxt = ia_r + 1'b1;
          end
          if (take_b) begin
            ib_nxt = ib_r + 1'b1;
          end
          if (emit_c && room) begin
            if (pend_v_r) begin
              ov_nxt    = 1'b1;
              os_nxt    = stsm_pkg::ST_ENTRY;
              orow_nxt  = pend_row_r;
              ocol_nxt  = pend_col_r;
              oval_nxt  = pend_val_r;
              oidx_nxt  = pend_idx_r;
              orr_nxt   = ar_r;
              orc_nxt   = ac_r;
              olast_nxt = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_row_nxt = take_a ? ka[15:8] : kb[15:8];
            pend_col_nxt = take_a ? ka[7:0] : kb[7:0];
            pend_val_nxt = diff;
            pend_idx_nxt = n_r[stsm_pkg::IDX_W-1:0];
            n_nxt        = n_r + 1'b1;
          end
          state_nxt = S_FETCH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          orr_nxt   = ar_r;
          orc_nxt   = ac_r;
          olast_nxt = 1'b1;
          if (pend_v_r) begin
            os_nxt   = stsm_pkg::ST_ENTRY;
            orow_nxt = pend_row_r;
            ocol_nxt = pend_col_r;
            oval_nxt = pend_val_r;
            oidx_nxt = pend_idx_r;
          end else begin
            os_nxt   = stsm_pkg::ST_EMPTY;
            orow_nxt = '0;
            ocol_nxt = '0;
            oval_nxt = '0;
            oidx_nxt = '0;
          end
          pend_v_nxt = 1'b0;
          cnt_a_nxt  = '0;
          cnt_b_nxt  = '0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_a_r  <= '0;
      cnt_b_r  <= '0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_a_r  <= cnt_a_nxt;
      cnt_b_r  <= cnt_b_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ia_r       <= ia_nxt;
    ib_r       <= ib_nxt;
    n_r        <= n_nxt;
    ar_r       <= ar_nxt;
    ac_r       <= ac_nxt;
    pend_row_r <= pend_row_nxt;
    pend_col_r <= pend_col_nxt;
    pend_val_r <= pend_val_nxt;
    pend_idx_r <= pend_idx_nxt;
    os_r       <= os_nxt;
    orow_r     <= orow_nxt;
    ocol_r     <= ocol_nxt;
    oval_r     <= oval_nxt;
    oidx_r     <= oidx_nxt;
    orr_r      <= orr_nxt;
    orc_r      <= orc_nxt;
    olast_r    <= olast_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_row         = orow_r;
  assign out_col         = ocol_r;
  assign out_value       = oval_r;
  assign out_entry_index = oidx_r;
  assign out_result_rows = orr_r;
  assign out_result_cols = orc_r;
  assign out_last        = olast_r;

endmodule

// ===== design/stsm_checker.sv =====
// Port-level checker for the sparse triplet subtract merge unit, with its bind.
module stsm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [32:0] out_value,
  input logic [5:0]  out_entry_index,
  input logic [8:0]  out_result_rows,
  input logic [8:0]  out_result_cols,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_value) &&
      $stable(out_entry_index) && $stable(out_last))
    else $error("result changed while stalled");

  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result register blocked");

  a_status_only_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == stsm_pkg::ST_MISMATCH || out_status == stsm_pkg::ST_FULL)
      |-> out_last && out_value == 33'd0 && out_result_rows == 9'd0 &&
          out_result_cols == 9'd0 && out_entry_index == 6'd0)
    else $error("status item carries data");

  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == stsm_pkg::ST_EMPTY
      |-> out_last && out_entry_index == 6'd0 && out_result_rows != 9'd0)
    else $error("malformed empty result");

endmodule

bind sparse_triplet_subtract_merge_unit stsm_checker u_stsm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_value       (out_value),
  .out_entry_index (out_entry_index),
  .out_result_rows (out_result_rows),
  .out_result_cols (out_result_cols),
  .out_last        (out_last)
);
